### src/pncm_pkg.sv
package pncm_pkg;

	localparam int PAL_SIZE   = 16;
	localparam int IDX_W      = $clog2(PAL_SIZE);
	localparam int FRAC_BITS  = 15;
	localparam int CBRT_SHIFT = 2 * FRAC_BITS - 16;
	localparam int LAB_W      = FRAC_BITS + 2;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] MODE_SRGB  = 2'd0;
	localparam logic [1:0] MODE_OKLAB = 2'd1;
	localparam logic [1:0] MODE_HYAB  = 2'd2;

	localparam logic [1:0] CFG_METRIC = 2'd0;
	localparam logic [1:0] CFG_CHROMA = 2'd1;
	localparam logic [1:0] CFG_LIGHT  = 2'd2;

	typedef logic signed [LAB_W-1:0] lab_val_t;

	typedef struct packed {
		lab_val_t l;
		lab_val_t a;
		lab_val_t b;
	} oklab_t;

	typedef enum logic [2:0] {
		OK_IDLE,
		OK_LMS,
		OK_SQ,
		OK_CU,
		OK_LAB,
		OK_DONE
	} ok_state_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CONV,
		ST_RD,
		ST_DIFF,
		ST_SQ,
		ST_SQRT,
		ST_WT,
		ST_CMP,
		ST_RESULT
	} st_state_t;

	typedef logic [23:0] color_tab_t [PAL_SIZE];
	typedef logic [15:0] lin_tab_t [256];
	typedef logic [15:0] lms_tab_t [9];
	typedef logic signed [17:0] lab_tab_t [9];

	localparam color_tab_t DEFAULT_COLORS = '{
		24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000,
		24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF,
		24'h808000, 24'h8080FF, 24'h800080, 24'h80FF80,
		24'h008080, 24'hFF8080, 24'h555555, 24'hAAAAAA
	};

	function automatic longint unsigned pow5_q30(input longint unsigned t);
		longint unsigned t2;
		longint unsigned t4;
		t2 = (t * t) >> 30;
		t4 = (t2 * t2) >> 30;
		return (t4 * t) >> 30;
	endfunction

	function automatic lin_tab_t build_lin();
		lin_tab_t tab;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned v;
		for (int c = 0; c < 256; c++) begin
			if (c <= 10) begin
				v = (longint'(c) * 64'd6553600 + 64'd164730) / 64'd329460;
			end else begin
				u = ((longint'(1000 * c + 14025)) << 30) / 64'd269025;
				u2 = (u * u) >> 30;
				lo = 0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					if (pow5_q30(mid) <= u2) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				v = (((u2 * lo) >> 30) + 64'd8192) >> 14;
			end
			tab[c] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
		end
		return tab;
	endfunction

	function automatic longint quant_coef(input longint k);
		longint unsigned mag;
		longint unsigned q;
		mag = (k < 0) ? longint'(-k) : longint'(k);
		q = (mag * (64'd1 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
		return (k < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic lms_tab_t build_lms();
		lms_tab_t tab;
		longint k [9];
		longint q;
		k = '{64'sd4122214708, 64'sd5363325363, 64'sd514459929,
			64'sd2119034982, 64'sd6806995451, 64'sd1073969566,
			64'sd883024619, 64'sd2817188376, 64'sd6299787005};
		for (int i = 0; i < 9; i++) begin
			q = quant_coef(k[i]);
			tab[i] = q[15:0];
		end
		return tab;
	endfunction

	function automatic lab_tab_t build_lab();
		lab_tab_t tab;
		longint k [9];
		longint q;
		k = '{64'sd2104542553, 64'sd7936177850, -64'sd40720468,
			64'sd19779984951, -64'sd24285922050, 64'sd4505937099,
			64'sd259040371, 64'sd7827717662, -64'sd8086757660};
		for (int i = 0; i < 9; i++) begin
			q = quant_coef(k[i]);
			tab[i] = q[17:0];
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin();
	localparam lms_tab_t LMS_Q   = build_lms();
	localparam lab_tab_t LAB_Q   = build_lab();

endpackage

### src/pncm_oklab.sv
module pncm_oklab (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [23:0]     rgb,
	output logic            done,
	output pncm_pkg::oklab_t lab
);

	pncm_pkg::ok_state_t state_q, state_d;

	logic [1:0]  row_q;
	logic [1:0]  col_q;
	logic [3:0]  bit_q;
	logic [15:0] lin_q [3];
	logic [32:0] x_q;
	logic [15:0] yw_q;
	logic [31:0] sq_q;
	logic [15:0] y_q [3];
	logic signed [36:0] acc_q;
	pncm_pkg::oklab_t lab_q;

	logic [3:0]  coef_idx;
	logic [31:0] lms_prod;
	logic [15:0] cand;
	logic [47:0] cube;
	logic [47:0] target;
	logic        cube_ok;
	logic signed [34:0] lab_prod;
	logic signed [36:0] acc_sum;
	logic [36:0] mag;
	logic [21:0] rnd;
	logic [21:0] rnd_s;

	assign coef_idx = {2'b00, row_q} * 4'd3 + {2'b00, col_q};
	assign lms_prod = pncm_pkg::LMS_Q[coef_idx] * lin_q[col_q];
	assign cand     = yw_q | (16'd1 << bit_q);
	assign cube     = {16'd0, sq_q} * {32'd0, cand};
	assign target   = {{(15 - pncm_pkg::CBRT_SHIFT){1'b0}}, x_q, {pncm_pkg::CBRT_SHIFT{1'b0}}};
	assign cube_ok  = cube <= target;
	assign lab_prod = pncm_pkg::LAB_Q[coef_idx] * $signed({1'b0, y_q[col_q]});
	assign acc_sum  = acc_q + {{2{lab_prod[34]}}, lab_prod};
	assign mag      = acc_sum[36] ? 37'(-acc_sum) : 37'(acc_sum);
	assign rnd      = 22'((mag + 37'(1 << (pncm_pkg::FRAC_BITS - 1))) >> pncm_pkg::FRAC_BITS);
	assign rnd_s    = acc_sum[36] ? -rnd : rnd;

	assign done = state_q == pncm_pkg::OK_DONE;
	assign lab  = lab_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pncm_pkg::OK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pncm_pkg::OK_IDLE: begin
				if (start) state_d = pncm_pkg::OK_LMS;
			end
			pncm_pkg::OK_LMS: begin
				if (col_q == 2'd2) state_d = pncm_pkg::OK_SQ;
			end
			pncm_pkg::OK_SQ: state_d = pncm_pkg::OK_CU;
			pncm_pkg::OK_CU: begin
				if (bit_q != 4'd0) state_d = pncm_pkg::OK_SQ;
				else if (row_q == 2'd2) state_d = pncm_pkg::OK_LAB;
				else state_d = pncm_pkg::OK_LMS;
			end
			pncm_pkg::OK_LAB: begin
				if (col_q == 2'd2 && row_q == 2'd2) state_d = pncm_pkg::OK_DONE;
			end
			pncm_pkg::OK_DONE: state_d = pncm_pkg::OK_IDLE;
			default: state_d = pncm_pkg::OK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pncm_pkg::OK_IDLE: begin
				lin_q[0] <= pncm_pkg::LIN_TAB[rgb[23:16]];
				lin_q[1] <= pncm_pkg::LIN_TAB[rgb[15:8]];
				lin_q[2] <= pncm_pkg::LIN_TAB[rgb[7:0]];
				x_q      <= '0;
				row_q    <= '0;
				col_q    <= '0;
				acc_q    <= '0;
			end
			pncm_pkg::OK_LMS: begin
				x_q <= x_q + {1'b0, lms_prod};
				if (col_q == 2'd2) begin
					col_q <= '0;
					bit_q <= 4'd15;
					yw_q  <= '0;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
			pncm_pkg::OK_SQ: begin
				sq_q <= cand * cand;
			end
			pncm_pkg::OK_CU: begin
				if (cube_ok) yw_q <= cand;
				if (bit_q == 4'd0) begin
					y_q[row_q] <= cube_ok ? cand : yw_q;
					col_q      <= '0;
					x_q        <= '0;
					acc_q      <= '0;
					row_q      <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
				end else begin
					bit_q <= bit_q - 4'd1;
				end
			end
			pncm_pkg::OK_LAB: begin
				if (col_q == 2'd2) begin
					case (row_q)
						2'd0:    lab_q.l <= rnd_s[pncm_pkg::LAB_W-1:0];
						2'd1:    lab_q.a <= rnd_s[pncm_pkg::LAB_W-1:0];
						default: lab_q.b <= rnd_s[pncm_pkg::LAB_W-1:0];
					endcase
					acc_q <= '0;
					col_q <= '0;
					row_q <= row_q + 2'd1;
				end else begin
					acc_q <= acc_sum;
					col_q <= col_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### src/palette_nearest_color_match_unit.sv
// nearest palette color match unit
// command channel: an item is taken at a clock edge with start high and busy low.
// req_type selects a palette write (entry_index, pixel_color) or a query
// (pixel_color). busy stays high until the item is finished.
// each query returns match_index for exactly one cycle with done high; the
// receiver cannot stall, it must take the transfer in that cycle. writes
// return nothing.
// every item first goes through the OkLab conversion sequencer: three row sums,
// a bit-serial 16-bit cube root per row with a square and a cube step per bit,
// then the Lab sums and a done state; a write is then done. a query then scans
// the 16 palette entries through the palette memory, each entry passing read,
// difference, square, weight and compare states, with a bit-serial square root
// between square and weight in HyAB mode; done follows the last compare.
// after reset the unit loads the sixteen default colors and their OkLab
// values into the palette memory, one conversion per entry; busy is high for
// that pass. config writes are taken at any time but are meant for when the
// unit is idle.
module palette_nearest_color_match_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [3:0]  entry_index,
	input  logic [23:0] pixel_color,
	output logic        done,
	output logic [3:0]  match_index,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_wr_data
);

	pncm_pkg::st_state_t state_q, state_d;

	logic [1:0] mode_q;
	logic [2:0] cw_q;
	logic [2:0] lw_q;

	logic        init_q;
	logic [pncm_pkg::IDX_W-1:0] idx_q;
	logic [pncm_pkg::IDX_W-1:0] best_q;
	logic [41:0] best_d_q;
	logic        req_q;
	logic [3:0]  slot_q;
	logic [23:0] pix_q;

	logic        conv_start;
	logic [23:0] conv_rgb;
	logic        conv_done;
	pncm_pkg::oklab_t conv_lab;

	logic        mem_we;
	logic [pncm_pkg::IDX_W-1:0] mem_waddr;
	logic [23:0] mem_wrgb;
	logic [23:0] rgb_mem [pncm_pkg::PAL_SIZE];
	pncm_pkg::oklab_t lab_mem [pncm_pkg::PAL_SIZE];
	logic [23:0] rd_rgb_s1;
	pncm_pkg::oklab_t rd_lab_s1;

	logic signed [8:0]  dr_q, dg_q, dbl_q;
	logic signed [17:0] dl_q, da_q, db_q;
	logic [17:0] rgbd_q;
	logic [35:0] dl2_q;
	logic [35:0] chroma_q;
	logic [17:0] absdl_q;
	logic [17:0] sqrt_q;
	logic [4:0]  sbit_q;
	logic [41:0] dist_q;

	logic [17:0] scand;
	logic [35:0] scand_sq;
	logic        is_ok;
	logic        is_hyab;
	logic [pncm_pkg::IDX_W-1:0] last_idx;

	assign last_idx = pncm_pkg::IDX_W'(pncm_pkg::PAL_SIZE - 1);
	assign is_ok    = mode_q == pncm_pkg::MODE_OKLAB;
	assign is_hyab  = mode_q == pncm_pkg::MODE_HYAB;
	assign scand    = sqrt_q | (18'd1 << sbit_q);
	assign scand_sq = scand * scand;

	assign busy        = state_q != pncm_pkg::ST_IDLE;
	assign done        = state_q == pncm_pkg::ST_RESULT;
	assign match_index = 4'(best_q);

	assign conv_rgb  = (state_q == pncm_pkg::ST_INIT) ? pncm_pkg::DEFAULT_COLORS[idx_q] : pixel_color;
	assign mem_waddr = init_q ? idx_q : slot_q[pncm_pkg::IDX_W-1:0];
	assign mem_wrgb  = init_q ? pncm_pkg::DEFAULT_COLORS[idx_q] : pix_q;

	pncm_oklab u_oklab (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.rgb    (conv_rgb),
		.done   (conv_done),
		.lab    (conv_lab)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pncm_pkg::MODE_SRGB;
			cw_q   <= 3'd1;
			lw_q   <= 3'd4;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pncm_pkg::CFG_METRIC: mode_q <= cfg_wr_data[1:0];
				pncm_pkg::CFG_CHROMA: cw_q   <= cfg_wr_data;
				pncm_pkg::CFG_LIGHT:  lw_q   <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rgb_mem[mem_waddr] <= mem_wrgb;
			lab_mem[mem_waddr] <= conv_lab;
		end
		rd_rgb_s1 <= rgb_mem[idx_q];
		rd_lab_s1 <= lab_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pncm_pkg::ST_INIT;
			init_q  <= 1'b1;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pncm_pkg::ST_CONV: begin
					if (conv_done) begin
						if (init_q) begin
							idx_q <= idx_q + 1'b1;
							if (idx_q == last_idx) init_q <= 1'b0;
						end else begin
							idx_q <= '0;
						end
					end
				end
				pncm_pkg::ST_CMP: begin
					if (idx_q != last_idx) idx_q <= idx_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d    = state_q;
		conv_start = 1'b0;
		mem_we     = 1'b0;
		case (state_q)
			pncm_pkg::ST_INIT: begin
				conv_start = 1'b1;
				state_d    = pncm_pkg::ST_CONV;
			end
			pncm_pkg::ST_IDLE: begin
				if (start) begin
					conv_start = 1'b1;
					state_d    = pncm_pkg::ST_CONV;
				end
			end
			pncm_pkg::ST_CONV: begin
				if (conv_done) begin
					if (init_q) begin
						mem_we  = 1'b1;
						state_d = (idx_q == last_idx) ? pncm_pkg::ST_IDLE : pncm_pkg::ST_INIT;
					end else if (req_q == pncm_pkg::REQ_WRITE) begin
						mem_we  = 1'b1;
						state_d = pncm_pkg::ST_IDLE;
					end else begin
						state_d = pncm_pkg::ST_RD;
					end
				end
			end
			pncm_pkg::ST_RD:   state_d = pncm_pkg::ST_DIFF;
			pncm_pkg::ST_DIFF: state_d = pncm_pkg::ST_SQ;
			pncm_pkg::ST_SQ:   state_d = is_hyab ? pncm_pkg::ST_SQRT : pncm_pkg::ST_WT;
			pncm_pkg::ST_SQRT: begin
				if (sbit_q == 5'd0) state_d = pncm_pkg::ST_WT;
			end
			pncm_pkg::ST_WT:   state_d = pncm_pkg::ST_CMP;
			pncm_pkg::ST_CMP: begin
				state_d = (idx_q == last_idx) ? pncm_pkg::ST_RESULT : pncm_pkg::ST_RD;
			end
			pncm_pkg::ST_RESULT: state_d = pncm_pkg::ST_IDLE;
			default: state_d = pncm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pncm_pkg::ST_IDLE: begin
				req_q  <= req_type;
				slot_q <= entry_index;
				pix_q  <= pixel_color;
			end
			pncm_pkg::ST_DIFF: begin
				dr_q  <= $signed({1'b0, pix_q[23:16]}) - $signed({1'b0, rd_rgb_s1[23:16]});
				dg_q  <= $signed({1'b0, pix_q[15:8]}) - $signed({1'b0, rd_rgb_s1[15:8]});
				dbl_q <= $signed({1'b0, pix_q[7:0]}) - $signed({1'b0, rd_rgb_s1[7:0]});
				dl_q  <= {conv_lab.l[16], conv_lab.l} - {rd_lab_s1.l[16], rd_lab_s1.l};
				da_q  <= {conv_lab.a[16], conv_lab.a} - {rd_lab_s1.a[16], rd_lab_s1.a};
				db_q  <= {conv_lab.b[16], conv_lab.b} - {rd_lab_s1.b[16], rd_lab_s1.b};
			end
			pncm_pkg::ST_SQ: begin
				rgbd_q   <= 18'(dr_q * dr_q) + 18'(dg_q * dg_q) + 18'(dbl_q * dbl_q);
				dl2_q    <= 36'(dl_q * dl_q);
				chroma_q <= 36'(da_q * da_q) + 36'(db_q * db_q);
				absdl_q  <= dl_q[17] ? 18'(-dl_q) : 18'(dl_q);
				sqrt_q   <= '0;
				sbit_q   <= 5'd17;
			end
			pncm_pkg::ST_SQRT: begin
				if (scand_sq <= chroma_q) sqrt_q <= scand;
				if (sbit_q != 5'd0) sbit_q <= sbit_q - 5'd1;
			end
			pncm_pkg::ST_WT: begin
				if (is_ok) begin
					dist_q <= 42'(lw_q) * 42'(dl2_q) + ((42'(cw_q) * 42'(chroma_q)) << 2);
				end else if (is_hyab) begin
					dist_q <= 42'(absdl_q) + 42'(cw_q) * 42'(sqrt_q);
				end else begin
					dist_q <= 42'(rgbd_q);
				end
			end
			pncm_pkg::ST_CMP: begin
				if (idx_q == '0 || dist_q < best_d_q) begin
					best_q   <= idx_q;
					best_d_q <= dist_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_we_at_conv_end: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> conv_done)
		else $error("palette write outside conversion end");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after transfer");

	a_no_result_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !done)
		else $error("result during palette load");
`endif

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_ITEMS = 1800;

	typedef longint lab3_t [3];

	class match_scoreboard;
		logic [15:0] lin_lut [256];
		longint lms_coef [9];
		longint lab_coef [9];
		logic [23:0] pal_rgb [16];
		longint pal_lab [16][3];
		logic [1:0] mode;
		logic [2:0] chroma_w;
		logic [2:0] light_w;
		logic [3:0] pending_idx [$];
		int mismatches;
		int results_seen;
		int queries;
		int writes;

		function longint unsigned p5(longint unsigned t);
			longint unsigned t2;
			longint unsigned t4;
			t2 = (t * t) >> 30;
			t4 = (t2 * t2) >> 30;
			return (t4 * t) >> 30;
		endfunction

		function longint fixq(longint k);
			longint unsigned mag;
			longint unsigned q;
			mag = (k < 0) ? -k : k;
			q = (mag * 64'd32768 + 64'd5000000000) / 64'd10000000000;
			return (k < 0) ? -longint'(q) : longint'(q);
		endfunction

		function new();
			longint unsigned u;
			longint unsigned u2;
			longint unsigned lo;
			longint unsigned hi;
			longint unsigned mid;
			longint unsigned v;
			longint lk [9];
			longint bk [9];
			lk = '{64'sd4122214708, 64'sd5363325363, 64'sd514459929, 64'sd2119034982,
				64'sd6806995451, 64'sd1073969566, 64'sd883024619, 64'sd2817188376,
				64'sd6299787005};
			bk = '{64'sd2104542553, 64'sd7936177850, -64'sd40720468, 64'sd19779984951,
				-64'sd24285922050, 64'sd4505937099, 64'sd259040371, 64'sd7827717662,
				-64'sd8086757660};
			for (int c = 0; c < 256; c++) begin
				if (c <= 10) begin
					v = (longint'(c) * 6553600 + 164730) / 329460;
				end else begin
					u = (longint'(1000 * c + 14025) << 30) / 269025;
					u2 = (u * u) >> 30;
					lo = 0;
					hi = 64'd1 << 30;
					while (lo < hi) begin
						mid = (lo + hi + 1) >> 1;
						if (p5(mid) <= u2) begin
							lo = mid;
						end else begin
							hi = mid - 1;
						end
					end
					v = (((u2 * lo) >> 30) + 8192) >> 14;
				end
				lin_lut[c] = (v > 65535) ? 16'hFFFF : v[15:0];
			end
			for (int i = 0; i < 9; i++) begin
				lms_coef[i] = fixq(lk[i]);
				lab_coef[i] = fixq(bk[i]);
			end
			mode = pncm_pkg::MODE_SRGB;
			chroma_w = 3'd1;
			light_w = 3'd4;
			for (int i = 0; i < 16; i++) begin
				pal_rgb[i] = pncm_pkg::DEFAULT_COLORS[i];
				pal_lab[i] = oklab_of(pncm_pkg::DEFAULT_COLORS[i]);
			end
		endfunction

		function lab3_t oklab_of(logic [23:0] rgb);
			longint unsigned lin [3];
			longint unsigned y [3];
			longint unsigned x;
			logic [127:0] rhs;
			logic [127:0] c3;
			longint unsigned cand;
			longint acc;
			longint unsigned mag;
			lab3_t res;
			lin[0] = lin_lut[rgb[23:16]];
			lin[1] = lin_lut[rgb[15:8]];
			lin[2] = lin_lut[rgb[7:0]];
			for (int r = 0; r < 3; r++) begin
				x = 0;
				for (int k = 0; k < 3; k++) x += lms_coef[3*r+k] * lin[k];
				rhs = 128'(x) << pncm_pkg::CBRT_SHIFT;
				y[r] = 0;
				for (int b = pncm_pkg::FRAC_BITS; b >= 0; b--) begin
					cand = y[r] | (64'd1 << b);
					c3 = 128'(cand);
					c3 = c3 * c3 * c3;
					if (c3 <= rhs) y[r] = cand;
				end
			end
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += lab_coef[3*r+k] * longint'(y[k]);
				mag = (acc < 0) ? -acc : acc;
				mag = (mag + (64'd1 << (pncm_pkg::FRAC_BITS - 1))) >> pncm_pkg::FRAC_BITS;
				res[r] = (acc < 0) ? -longint'(mag) : longint'(mag);
			end
			return res;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned cand;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				cand = r | (64'd1 << b);
				if (cand * cand <= v) r = cand;
			end
			return r;
		endfunction

		function void set_reg(logic [1:0] idx, logic [2:0] val);
			case (idx)
				pncm_pkg::CFG_METRIC: mode = val[1:0];
				pncm_pkg::CFG_CHROMA: chroma_w = val;
				pncm_pkg::CFG_LIGHT: light_w = val;
				default: ;
			endcase
		endfunction

		function void note_item(logic rt, logic [3:0] slot, logic [23:0] rgb);
			lab3_t q;
			longint dl;
			longint da;
			longint db;
			longint dr;
			longint dg;
			longint dbl;
			longint unsigned d;
			longint unsigned best_d;
			int best;
			if (rt == pncm_pkg::REQ_WRITE) begin
				pal_rgb[slot] = rgb;
				pal_lab[slot] = oklab_of(rgb);
				writes++;
				return;
			end
			queries++;
			q = oklab_of(rgb);
			best = 0;
			best_d = 0;
			for (int i = 0; i < 16; i++) begin
				if (mode == pncm_pkg::MODE_OKLAB || mode == pncm_pkg::MODE_HYAB) begin
					dl = q[0] - pal_lab[i][0];
					da = q[1] - pal_lab[i][1];
					db = q[2] - pal_lab[i][2];
					if (mode == pncm_pkg::MODE_OKLAB) begin
						d = light_w * dl * dl + 4 * chroma_w * (da * da + db * db);
					end else begin
						d = ((dl < 0) ? -dl : dl) + chroma_w * int_sqrt(da * da + db * db);
					end
				end else begin
					dr = longint'(rgb[23:16]) - longint'(pal_rgb[i][23:16]);
					dg = longint'(rgb[15:8]) - longint'(pal_rgb[i][15:8]);
					dbl = longint'(rgb[7:0]) - longint'(pal_rgb[i][7:0]);
					d = dr * dr + dg * dg + dbl * dbl;
				end
				if (i == 0 || d < best_d) begin
					best_d = d;
					best = i;
				end
			end
			pending_idx.push_back(4'(best));
		endfunction

		function void check_match(logic [3:0] got);
			logic [3:0] want;
			results_seen++;
			if (pending_idx.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected match_index %0d", got);
				return;
			end
			want = pending_idx.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("match_index mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic req_type;
	logic [3:0] entry_index;
	logic [23:0] pixel_color;
	logic done;
	logic [3:0] match_index;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [2:0] cfg_wr_data;

	match_scoreboard sb;
	longint cycles;

	palette_nearest_color_match_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.entry_index(entry_index),
		.pixel_color(pixel_color),
		.done(done),
		.match_index(match_index),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("palette_nearest_color_match_unit regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_match(match_index);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 150);
	endfunction

	task automatic transfer(logic rt, logic [3:0] slot, logic [23:0] rgb, int gap);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		req_type = rt;
		entry_index = slot;
		pixel_color = rgb;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sb.note_item(rt, slot, rgb);
	endtask

	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending_idx.size() != 0 || busy) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [2:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wr_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.set_reg(idx, val);
	endtask

	function automatic logic [23:0] rand_color();
		logic [23:0] c;
		int r;
		r = $urandom_range(0, 9);
		c = 24'($urandom);
		if (r < 3) begin
			c = sb.pal_rgb[$urandom_range(0, 15)] ^ 24'($urandom_range(0, 7) << (8 * $urandom_range(0, 2)));
		end else if (r == 3) begin
			for (int k = 0; k < 3; k++) c[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end else if (r == 4) begin
			for (int k = 0; k < 3; k++) c[8*k +: 8] = 8'($urandom_range(0, 12));
		end
		return c;
	endfunction

	initial begin
		logic [2:0] settings [12][3];
		int per_phase;
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = pncm_pkg::REQ_WRITE;
		entry_index = 4'd0;
		pixel_color = 24'd0;
		cfg_wr_en = 1'b0;
		cfg_index = pncm_pkg::CFG_METRIC;
		cfg_wr_data = 3'd0;
		settings = '{
			'{3'(pncm_pkg::MODE_SRGB), 3'd1, 3'd4}, '{3'(pncm_pkg::MODE_OKLAB), 3'd1, 3'd4},
			'{3'(pncm_pkg::MODE_HYAB), 3'd1, 3'd4}, '{3'(pncm_pkg::MODE_OKLAB), 3'd4, 3'd1},
			'{3'(pncm_pkg::MODE_HYAB), 3'd4, 3'd1}, '{3'd3, 3'd2, 3'd2},
			'{3'(pncm_pkg::MODE_OKLAB), 3'd0, 3'd7}, '{3'(pncm_pkg::MODE_OKLAB), 3'd7, 3'd0},
			'{3'(pncm_pkg::MODE_HYAB), 3'd0, 3'd4}, '{3'(pncm_pkg::MODE_HYAB), 3'd7, 3'd7},
			'{3'(pncm_pkg::MODE_OKLAB), 3'd2, 3'd3}, '{3'(pncm_pkg::MODE_SRGB), 3'd7, 3'd0}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults, extremes, ties and slot edges
		for (int i = 0; i < 16; i++)
			transfer(pncm_pkg::REQ_QUERY, 4'($urandom), pncm_pkg::DEFAULT_COLORS[i], 0);
		transfer(pncm_pkg::REQ_QUERY, 4'd0, 24'h7F7F7F, pick_gap());
		transfer(pncm_pkg::REQ_WRITE, 4'd15, 24'h000000, 0);
		transfer(pncm_pkg::REQ_QUERY, 4'd0, 24'h000000, 0);
		transfer(pncm_pkg::REQ_WRITE, 4'd0, 24'hFFFFFF, 0);
		transfer(pncm_pkg::REQ_QUERY, 4'd0, 24'hFFFFFF, 0);
		transfer(pncm_pkg::REQ_QUERY, 4'd0, 24'h010203, 0);
		transfer(pncm_pkg::REQ_WRITE, 4'd0, 24'h000000, 0);
		transfer(pncm_pkg::REQ_WRITE, 4'd15, 24'hAAAAAA, 0);
		settle();
		write_cfg(CFG_UNUSED, 3'd7);
		transfer(pncm_pkg::REQ_QUERY, 4'd0, 24'h00FF00, 0);
		settle();

		per_phase = RANDOM_ITEMS / 12;
		for (int p = 0; p < 12; p++) begin
			write_cfg(pncm_pkg::CFG_METRIC, settings[p][0]);
			write_cfg(pncm_pkg::CFG_CHROMA, settings[p][1]);
			write_cfg(pncm_pkg::CFG_LIGHT, settings[p][2]);
			for (int n = 0; n < per_phase; n++) begin
				if ($urandom_range(0, 99) < 25) begin
					transfer(pncm_pkg::REQ_WRITE, 4'($urandom), rand_color(), pick_gap());
				end else begin
					transfer(pncm_pkg::REQ_QUERY, 4'($urandom), rand_color(), pick_gap());
				end
			end
			settle();
		end

		$display("covered %0d queries and %0d palette writes over 12 metric and weight settings",
			sb.queries, sb.writes);
		$display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_idx.size() == 0) begin
			$display("palette_nearest_color_match_unit regression: pass");
		end else begin
			$display("palette_nearest_color_match_unit regression: fail");
		end
		$finish;
	end

endmodule
